FILE: rtl/core/pert_pkg.sv
// ============================================================================
// pert_pkg
// Shared types and constants of the position exposure and drawdown tracker.
// ============================================================================
`default_nettype none

package pert_pkg;

    localparam int SLOTS_DEFAULT = 256;
    localparam int TABLE_MAX     = 256;   // symbol_index is 8 bits

    localparam int VALUE_W  = 24;
    localparam int SUM_W    = 32;
    localparam int SQSUM_W  = 55;
    localparam int SQ_W     = 48;
    localparam int PNL_W    = 48;
    localparam int MAG_W    = 47;
    localparam int DELTA_W  = 40;
    localparam int CONC_W   = 17;
    localparam int CFG_W    = 47;
    localparam int CFG_AW   = 2;

    localparam logic [CFG_AW-1:0] CFG_POSITION_LIMIT  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_STOP_LOSS_LIMIT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_DRAWDOWN_LIMIT  = 2'd2;

    localparam logic [VALUE_W-1:0] POSITION_LIMIT_RST  = 24'd1000000;
    localparam logic [MAG_W-1:0]   STOP_LOSS_LIMIT_RST = 47'd100000000;
    localparam logic [MAG_W-1:0]   DRAWDOWN_LIMIT_RST  = 47'd500000000;

    localparam logic KIND_POSITION = 1'b0;
    localparam logic KIND_PNL      = 1'b1;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 296;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIVW,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_MUL,
        DV_CHK,
        DV_ITER,
        DV_DONE
    } div_state_t;

    typedef struct packed {
        logic               start;
        logic [SQSUM_W-1:0] square_sum;
        logic [SUM_W-1:0]   gross;
    } conc_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/pert_ram.sv
// ============================================================================
// pert_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module pert_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/pert_conc.sv
// ============================================================================
// pert_conc
// Concentration index: floor(65536 * square_sum / gross^2), restoring divide,
// one quotient bit per cycle.
// ============================================================================
`default_nettype none

module pert_conc (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire pert_pkg::conc_req_t          req,
    output logic                              done,
    output logic [pert_pkg::CONC_W-1:0]       conc
);

    pert_pkg::div_state_t state_reg, state_next;

    logic [pert_pkg::SUM_W-1:0]   g_reg;
    logic [63:0]                  g2_reg;
    logic [63:0]                  r_reg;
    logic [pert_pkg::CONC_W-1:0]  q_reg;
    logic [3:0]                   cnt_reg;
    logic [63:0]                  r_shift;

    assign r_shift = {r_reg[62:0], 1'b0};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pert_pkg::DV_IDLE: if (req.start) state_next = pert_pkg::DV_MUL;
            pert_pkg::DV_MUL:  state_next = pert_pkg::DV_CHK;
            pert_pkg::DV_CHK: begin
                if (g_reg == '0 || r_reg >= g2_reg) state_next = pert_pkg::DV_DONE;
                else                               state_next = pert_pkg::DV_ITER;
            end
            pert_pkg::DV_ITER: if (cnt_reg == 4'd15) state_next = pert_pkg::DV_DONE;
            pert_pkg::DV_DONE: state_next = pert_pkg::DV_IDLE;
            default:           state_next = pert_pkg::DV_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == pert_pkg::DV_DONE);
        conc = q_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pert_pkg::DV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            pert_pkg::DV_IDLE: begin
                g_reg   <= req.gross;
                r_reg   <= 64'(req.square_sum);
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            pert_pkg::DV_MUL: begin
                // square sum is written on the start edge, take the settled value
                r_reg  <= 64'(req.square_sum);
                g2_reg <= 64'(g_reg) * 64'(g_reg);
            end
            pert_pkg::DV_CHK: begin
                if (g_reg == '0) begin
                    q_reg <= '0;
                end else if (r_reg >= g2_reg) begin
                    q_reg <= 17'h10000;
                end
            end
            pert_pkg::DV_ITER: begin
                cnt_reg <= cnt_reg + 4'd1;
                if (r_shift >= g2_reg) begin
                    r_reg <= r_shift - g2_reg;
                    q_reg <= {q_reg[15:0], 1'b1};
                end else begin
                    r_reg <= r_shift;
                    q_reg <= {q_reg[15:0], 1'b0};
                end
            end
            pert_pkg::DV_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pert_pkg::DV_ITER) |-> (g_reg != '0 && r_reg < g2_reg))
        else $error("divider iterating with remainder not below divisor");

    assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (q_reg <= 17'h10000))
        else $error("concentration above one");

    assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (state_reg == pert_pkg::DV_IDLE))
        else $error("divider did not return to idle");

endmodule

`default_nettype wire

FILE: rtl/core/position_exposure_risk_tracker.sv
// ============================================================================
// position_exposure_risk_tracker
// Per-symbol position table with exposure sums, concentration and pnl limits.
// ============================================================================
// Usage:
//   Input stream s_*: one transaction per item. s_tuser is kind (0 position,
//   1 pnl). Position items replace the table slot symbol_index and update the
//   gross, net, long, short and square sums; pnl items add both deltas to the
//   saturating total and track peak and worst drawdown.
//   Output stream m_*: exactly one result transaction per input item.
//   Config port cfg_*: write while idle; index 0 position limit, 1 stop loss,
//   2 drawdown limit; other indexes are ignored.
//   Steps from accept to m_tvalid: a table read, the update state, the sum
//   state, then the concentration divider (one multiply, one check, sixteen
//   one-bit restoring steps, a done state) and the output load. With zero
//   gross or a single position holding all of it the divider skips its
//   restoring steps. A new item is accepted only after the previous result
//   is loaded into the output register. One item in flight.
//   A result waiting on m_tready holds the output register; the block keeps
//   computing the next item and stalls only when that one is ready to issue.
//   Reset: all sums, pnl state and the table (through per-slot valid bits)
//   read as zero at once; limits return to their defaults.
// ============================================================================
`default_nettype none

module position_exposure_risk_tracker #(
    parameter int POSITION_SLOTS = pert_pkg::SLOTS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // tdata: symbol_index[7:0], position value[31:8], realized_delta[71:32],
    //        unrealized_delta[111:72]
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [pert_pkg::IN_TDATA_W-1:0]    s_tdata,
    // tuser: kind[0]
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // tdata: gross[31:0], net[63:32], long[95:64], short[127:96],
    //        concentration[144:128],
    //        total_pnl[192:145], peak_pnl[239:193], worst_drawdown[286:240],
    //        position_ok[287], stop_loss_ok[288], drawdown_ok[289], zeros above
    output logic      [pert_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [pert_pkg::CFG_AW-1:0]        cfg_addr,
    input  wire logic [pert_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int DEPTH = (POSITION_SLOTS < pert_pkg::TABLE_MAX) ?
                           POSITION_SLOTS : pert_pkg::TABLE_MAX;
    localparam int AW = $clog2(DEPTH);

    pert_pkg::state_t state_reg, state_next;

    // configuration
    logic [pert_pkg::VALUE_W-1:0] pos_limit_reg;
    logic [pert_pkg::MAG_W-1:0]   stop_limit_reg;
    logic [pert_pkg::MAG_W-1:0]   dd_limit_reg;

    // latched item
    logic                          kind_reg;
    logic [7:0]                    slot_reg;
    logic signed [pert_pkg::VALUE_W-1:0] mv_reg;
    logic signed [pert_pkg::DELTA_W-1:0] rd_reg;
    logic signed [pert_pkg::DELTA_W-1:0] ud_reg;

    // running state
    logic [DEPTH-1:0]              valid_reg;
    logic [pert_pkg::SUM_W-1:0]    gross_reg, net_reg, long_reg, short_reg;
    logic [pert_pkg::SQSUM_W-1:0]  sq_reg;
    logic [pert_pkg::SQ_W-1:0]     old_sq_reg, new_sq_reg;
    logic                          upd_sq_reg;
    logic signed [pert_pkg::PNL_W-1:0] total_reg;
    logic [pert_pkg::MAG_W-1:0]    peak_reg, dmax_reg;
    logic [pert_pkg::CONC_W-1:0]   conc_reg;
    logic                          m_tvalid_reg;
    logic [pert_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    // table
    logic                          ram_we;
    logic [AW-1:0]                 ram_raddr;
    logic [pert_pkg::VALUE_W-1:0]  ram_rdata;
    logic                          in_range;
    logic signed [pert_pkg::VALUE_W-1:0] old_val;
    logic [pert_pkg::VALUE_W-1:0]  old_mag, new_mag;

    // pnl
    logic signed [pert_pkg::PNL_W+1:0] pnl_sum;
    logic signed [pert_pkg::PNL_W-1:0] pnl_sat;
    logic signed [pert_pkg::PNL_W:0]   peak_ext, total_ext;
    logic [pert_pkg::MAG_W-1:0]        peak_new;
    logic signed [pert_pkg::PNL_W:0]   dd_new, dd_cur;
    logic [pert_pkg::MAG_W-1:0]        dd_new_sat;

    // results
    logic                          pos_ok;
    logic                          stop_ok, dd_ok;
    logic                          out_load;

    pert_pkg::conc_req_t           div_req;
    logic                          div_done;
    logic [pert_pkg::CONC_W-1:0]   div_q;

    assign s_tready = (state_reg == pert_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_range  = (32'(slot_reg) < POSITION_SLOTS);
    assign ram_raddr = s_tready ? s_tdata[AW-1:0] : slot_reg[AW-1:0];
    assign ram_we    = (state_reg == pert_pkg::ST_READ) &&
                       (kind_reg == pert_pkg::KIND_POSITION) && in_range;
    assign old_val   = valid_reg[slot_reg[AW-1:0]] ? ram_rdata : '0;
    assign old_mag   = old_val[pert_pkg::VALUE_W-1] ? 24'(-old_val) : 24'(old_val);
    assign new_mag   = mv_reg[pert_pkg::VALUE_W-1] ? 24'(-mv_reg) : 24'(mv_reg);

    pert_ram #(
        .WIDTH(pert_pkg::VALUE_W),
        .DEPTH(DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(slot_reg[AW-1:0]),
        .wdata(mv_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // pnl arithmetic
    always_comb begin
        pnl_sum = 50'(total_reg) + 50'(rd_reg) + 50'(ud_reg);
        if (pnl_sum > 50'sh7FFF_FFFF_FFFF) begin
            pnl_sat = 48'sh7FFF_FFFF_FFFF;
        end else if (pnl_sum < -50'sh8000_0000_0000) begin
            pnl_sat = 48'sh8000_0000_0000;
        end else begin
            pnl_sat = pnl_sum[pert_pkg::PNL_W-1:0];
        end
        peak_ext  = $signed({2'b00, peak_reg});
        total_ext = 49'(total_reg);
        peak_new  = (total_ext > peak_ext) ? total_reg[pert_pkg::MAG_W-1:0] : peak_reg;
        dd_new    = $signed({2'b00, peak_new}) - total_ext;
        dd_new_sat = dd_new[pert_pkg::PNL_W-1] ? 47'h7FFF_FFFF_FFFF
                                               : dd_new[pert_pkg::MAG_W-1:0];
        dd_cur    = peak_ext - total_ext;
        stop_ok   = total_ext > -$signed({2'b00, stop_limit_reg});
        dd_ok     = dd_cur < $signed({2'b00, dd_limit_reg});
        pos_ok    = (kind_reg == pert_pkg::KIND_PNL) || (new_mag <= pos_limit_reg);
    end

    assign div_req.start      = (state_reg == pert_pkg::ST_SUM);
    assign div_req.square_sum = sq_reg;
    assign div_req.gross      = gross_reg;

    // square_sum is written at the end of ST_SUM; the divider latches it in DV_MUL, the state after its start
    pert_conc u_conc (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .done   (div_done),
        .conc   (div_q)
    );

    assign out_load = (state_reg == pert_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pert_pkg::ST_IDLE: if (s_tvalid) state_next = pert_pkg::ST_READ;
            pert_pkg::ST_READ: state_next = pert_pkg::ST_SUM;
            pert_pkg::ST_SUM:  state_next = pert_pkg::ST_DIVW;
            pert_pkg::ST_DIVW: if (div_done) state_next = pert_pkg::ST_OUT;
            pert_pkg::ST_OUT:  if (out_load) state_next = pert_pkg::ST_IDLE;
            default:           state_next = pert_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pert_pkg::ST_IDLE;
            pos_limit_reg  <= pert_pkg::POSITION_LIMIT_RST;
            stop_limit_reg <= pert_pkg::STOP_LOSS_LIMIT_RST;
            dd_limit_reg   <= pert_pkg::DRAWDOWN_LIMIT_RST;
            valid_reg      <= '0;
            gross_reg      <= '0;
            net_reg        <= '0;
            long_reg       <= '0;
            short_reg      <= '0;
            sq_reg         <= '0;
            upd_sq_reg     <= 1'b0;
            total_reg      <= '0;
            peak_reg       <= '0;
            dmax_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    pert_pkg::CFG_POSITION_LIMIT:
                        pos_limit_reg <= cfg_wdata[pert_pkg::VALUE_W-1:0];
                    pert_pkg::CFG_STOP_LOSS_LIMIT: stop_limit_reg <= cfg_wdata;
                    pert_pkg::CFG_DRAWDOWN_LIMIT:  dd_limit_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (state_reg == pert_pkg::ST_READ) begin
                upd_sq_reg <= ram_we;
                if (ram_we) begin
                    valid_reg[slot_reg[AW-1:0]] <= 1'b1;
                    gross_reg <= gross_reg - 32'(old_mag) + 32'(new_mag);
                    net_reg   <= net_reg - 32'(old_val) + 32'(mv_reg);
                    long_reg  <= long_reg
                                 - ((old_val > 0) ? 32'(old_mag) : 32'd0)
                                 + ((mv_reg > 0) ? 32'(new_mag) : 32'd0);
                    short_reg <= short_reg
                                 - ((old_val > 0) ? 32'd0 : 32'(old_mag))
                                 + ((mv_reg > 0) ? 32'd0 : 32'(new_mag));
                end
                if (kind_reg == pert_pkg::KIND_PNL) begin
                    total_reg <= pnl_sat;
                end
            end
            if (state_reg == pert_pkg::ST_SUM) begin
                if (upd_sq_reg) begin
                    sq_reg <= sq_reg - 55'(old_sq_reg) + 55'(new_sq_reg);
                end
                if (kind_reg == pert_pkg::KIND_PNL) begin
                    peak_reg <= peak_new;
                    if (dd_new_sat > dmax_reg) dmax_reg <= dd_new_sat;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg <= s_tuser;
            slot_reg <= s_tdata[7:0];
            mv_reg   <= s_tdata[31:8];
            rd_reg   <= s_tdata[71:32];
            ud_reg   <= s_tdata[111:72];
        end
        if (state_reg == pert_pkg::ST_READ) begin
            old_sq_reg <= 48'(old_val * old_val);
            new_sq_reg <= 48'(mv_reg * mv_reg);
        end
        if (div_done) begin
            conc_reg <= div_q;
        end
        if (out_load) begin
            m_tdata_reg <= {6'd0, dd_ok, stop_ok, pos_ok, dmax_reg, peak_reg,
                            total_reg, conc_reg, short_reg, long_reg, net_reg,
                            gross_reg};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        gross_reg == long_reg + short_reg)
        else $error("gross exposure differs from long plus short");

    assert property (@(posedge aclk) disable iff (!aresetn)
        net_reg == long_reg - short_reg)
        else $error("net exposure differs from long minus short");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (kind_reg == pert_pkg::KIND_POSITION && state_reg == pert_pkg::ST_READ))
        else $error("table write outside position update");

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == pert_pkg::ST_DIVW))
        else $error("divider finished while not awaited");

endmodule

`default_nettype wire

FILE: verif/position_exposure_risk_tracker_test.sv
// ----------------------------------------------------------------------------
// position_exposure_risk_tracker_test
// Self-checking bench: a scoreboard models the position table, exposure sums,
// concentration and pnl/drawdown state, and checks every result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

class exposure_scoreboard;
    longint          pos_table [256];
    longint          gross, net, long_sum, short_sum;
    longint unsigned square_sum;
    longint          pnl_total, pnl_peak, drawdown_max;
    longint unsigned pos_limit, stop_limit, dd_limit;
    logic [pert_pkg::OUT_TDATA_W-1:0] expected_results [$];
    int              errors;

    function new();
        foreach (pos_table[i]) pos_table[i] = 0;
        gross = 0; net = 0; long_sum = 0; short_sum = 0; square_sum = 0;
        pnl_total = 0; pnl_peak = 0; drawdown_max = 0;
        pos_limit = 1000000; stop_limit = 100000000; dd_limit = 500000000;
        errors = 0;
    endfunction

    function void write_limit(logic [pert_pkg::CFG_AW-1:0] addr,
                              logic [pert_pkg::CFG_W-1:0] val);
        case (addr)
            pert_pkg::CFG_POSITION_LIMIT:  pos_limit = 64'(val[23:0]);
            pert_pkg::CFG_STOP_LOSS_LIMIT: stop_limit = 64'(val);
            pert_pkg::CFG_DRAWDOWN_LIMIT:  dd_limit = 64'(val);
            default: ;
        endcase
    endfunction

    function void apply_value(longint v, longint sgn);
        gross += sgn * (v < 0 ? -v : v);
        net += sgn * v;
        if (v > 0) long_sum += sgn * v;
        else short_sum -= sgn * v;
        if (sgn > 0) square_sum += longint'(v * v);
        else square_sum -= longint'(v * v);
    endfunction

    function longint unsigned concentration_q16();
        longint unsigned g2, r, q;
        if (gross <= 0) return 0;
        g2 = gross * gross;
        r = square_sum;
        q = 0;
        if (r >= g2) return 65536;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= g2) begin
                r -= g2;
                q |= 1;
            end
        end
        return q;
    endfunction

    function void note_item(logic kind, logic [pert_pkg::IN_TDATA_W-1:0] d);
        longint mv, t, dd;
        logic   pos_ok;
        logic [pert_pkg::OUT_TDATA_W-1:0] r;
        mv = longint'($signed(d[31:8]));
        pos_ok = 1'b1;
        if (kind == pert_pkg::KIND_POSITION) begin
            pos_ok = ((mv < 0 ? -mv : mv) <= longint'(pos_limit));
            apply_value(pos_table[d[7:0]], -1);
            pos_table[d[7:0]] = mv;
            apply_value(mv, 1);
        end else begin
            t = pnl_total + longint'($signed(d[71:32])) + longint'($signed(d[111:72]));
            if (t > 64'sh7FFF_FFFF_FFFF) t = 64'sh7FFF_FFFF_FFFF;
            if (t < -64'sh8000_0000_0000) t = -64'sh8000_0000_0000;
            pnl_total = t;
            if (t > pnl_peak) pnl_peak = t;
            dd = pnl_peak - t;
            if (dd > 64'sh7FFF_FFFF_FFFF) dd = 64'sh7FFF_FFFF_FFFF;
            if (dd > drawdown_max) drawdown_max = dd;
        end
        dd = pnl_peak - pnl_total;
        r = '0;
        r[31:0] = gross[31:0];
        r[63:32] = net[31:0];
        r[95:64] = long_sum[31:0];
        r[127:96] = short_sum[31:0];
        r[144:128] = 17'(concentration_q16());
        r[192:145] = pnl_total[47:0];
        r[239:193] = pnl_peak[46:0];
        r[286:240] = drawdown_max[46:0];
        r[287] = pos_ok;
        r[288] = (pnl_total > -longint'(stop_limit));
        r[289] = (longint'(dd) < longint'(dd_limit));
        expected_results.push_back(r);
    endfunction

    function void cmp(string nm, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, nm, e, a);
        end
    endfunction

    function void check_result(logic [pert_pkg::OUT_TDATA_W-1:0] a);
        logic [pert_pkg::OUT_TDATA_W-1:0] e;
        if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual %h", $time, a);
            return;
        end
        e = expected_results.pop_front();
        cmp("gross", 64'(e[31:0]), 64'(a[31:0]));
        cmp("net", 64'(e[63:32]), 64'(a[63:32]));
        cmp("long", 64'(e[95:64]), 64'(a[95:64]));
        cmp("short", 64'(e[127:96]), 64'(a[127:96]));
        cmp("concentration", 64'(e[144:128]), 64'(a[144:128]));
        cmp("total_pnl", 64'(e[192:145]), 64'(a[192:145]));
        cmp("peak_pnl", 64'(e[239:193]), 64'(a[239:193]));
        cmp("worst_drawdown", 64'(e[286:240]), 64'(a[286:240]));
        cmp("position_ok", 64'(e[287]), 64'(a[287]));
        cmp("stop_loss_ok", 64'(e[288]), 64'(a[288]));
        cmp("drawdown_ok", 64'(e[289]), 64'(a[289]));
        cmp("padding", 64'(e[295:290]), 64'(a[295:290]));
    endfunction
endclass

module position_exposure_risk_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint MAX_CYCLES = 1000000;
    localparam longint DELTA_MAX  = 64'sd549755813887;
    localparam longint DELTA_MIN  = -64'sd549755813888;
    localparam logic [46:0] LIM47_MAX = 47'h7FFF_FFFF_FFFF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [pert_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [pert_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [pert_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [pert_pkg::CFG_W-1:0] cfg_wdata = '0;

    exposure_scoreboard sb = new();
    longint cycles = 0;
    int     burst_left = 0;
    int     pnl_trend = 0;
    bit     hold_off_req = 0;

    position_exposure_risk_tracker i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // receiver: changing stall modes plus one long hold-off on request
    always @(negedge aclk) begin
        int mode_left, mode, hold_cnt;
        if (hold_off_req) begin
            hold_off_req = 0;
            hold_cnt = 600;
        end
        if (mode_left <= 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready = 1'b0;
        end else begin
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 1) == 1);
                2: m_tready = ($urandom_range(0, 7) == 0);
                default: m_tready = ((cycles % 5) != 0);
            endcase
        end
    end

    task automatic send_item(logic kind, logic [pert_pkg::IN_TDATA_W-1:0] d);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40)) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = d;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(kind, d);
        @(negedge aclk);
        if (burst_left == 0) s_tvalid = 1'b0;
    endtask

    function automatic logic [pert_pkg::IN_TDATA_W-1:0] pack_item(
            logic [7:0] slot, longint mv, longint rd, longint ud);
        return {ud[39:0], rd[39:0], mv[23:0], slot};
    endfunction

    task automatic drain();
        burst_left = 0;
        s_tvalid = 1'b0;
        while (sb.expected_results.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_limit(logic [pert_pkg::CFG_AW-1:0] a, logic [pert_pkg::CFG_W-1:0] v);
        cfg_we = 1'b1;
        cfg_addr = a;
        cfg_wdata = v;
        @(posedge aclk);
        sb.write_limit(a, v);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    function automatic longint rand_delta();
        longint v;
        v = longint'($signed({$urandom(), $urandom()} & 64'hFF_FFFF_FFFF) <<< 24) >>> 24;
        case (pnl_trend)
            1: v = DELTA_MAX - $urandom_range(0, 1000);
            2: v = DELTA_MIN + $urandom_range(0, 1000);
            3: v = longint'($urandom_range(0, 200000)) - 100000;
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_item();
        logic   kind;
        logic [7:0] slot;
        longint mv;
        logic [pert_pkg::IN_TDATA_W-1:0] d;
        kind = (pnl_trend == 1 || pnl_trend == 2) ? ($urandom_range(0, 9) < 8)
                                                   : 1'($urandom_range(0, 1));
        slot = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15))
                                          : 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: mv = 64'sd8388607;
            1: mv = -64'sd8388608;
            2: mv = 0;
            3: mv = longint'(sb.pos_limit) - $urandom_range(0, 1);
            4: mv = longint'($urandom_range(0, 2000)) - 1000;
            default: mv = longint'($signed(24'($urandom())));
        endcase
        d = pack_item(slot, mv, rand_delta(), rand_delta());
        send_item(kind, d);
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: extremes, replacement, limit edge, pnl saturation both ways
        send_item(pert_pkg::KIND_PNL, pack_item(0, 0, 0, 0));
        send_item(pert_pkg::KIND_POSITION, pack_item(0, 64'sd8388607, 0, 0));
        send_item(pert_pkg::KIND_POSITION, pack_item(1, -64'sd8388608, 0, 0));
        send_item(pert_pkg::KIND_POSITION, pack_item(255, 0, 0, 0));
        send_item(pert_pkg::KIND_POSITION, pack_item(2, 1000000, 0, 0));
        send_item(pert_pkg::KIND_POSITION, pack_item(3, -1000001, 0, 0));
        send_item(pert_pkg::KIND_POSITION, pack_item(0, 0, 0, 0));
        send_item(pert_pkg::KIND_POSITION, pack_item(1, 0, 0, 0));
        send_item(pert_pkg::KIND_POSITION, pack_item(2, 0, 0, 0));
        send_item(pert_pkg::KIND_POSITION, pack_item(3, 0, 0, 0));
        send_item(pert_pkg::KIND_POSITION, pack_item(254, 5, 0, 0));
        send_item(pert_pkg::KIND_POSITION, pack_item(7, -5, 0, 0));
        send_item(pert_pkg::KIND_PNL, pack_item(9, 77, DELTA_MAX, DELTA_MAX));
        send_item(pert_pkg::KIND_PNL, pack_item(0, 0, DELTA_MIN, DELTA_MIN));
        send_item(pert_pkg::KIND_PNL, pack_item(0, 0, -100000000, 0));
        send_item(pert_pkg::KIND_PNL, pack_item(0, 0, 0, -500000000));
        for (int i = 0; i < 140; i++) begin
            send_item(pert_pkg::KIND_PNL, pack_item(0, 0, DELTA_MAX, DELTA_MAX));
        end
        for (int i = 0; i < 280; i++) begin
            send_item(pert_pkg::KIND_PNL, pack_item(0, 0, DELTA_MIN, DELTA_MIN));
        end
        send_item(pert_pkg::KIND_PNL, pack_item(0, 0, DELTA_MAX, DELTA_MIN));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_limit(pert_pkg::CFG_POSITION_LIMIT, 47'd8388608);
                    write_limit(pert_pkg::CFG_STOP_LOSS_LIMIT, LIM47_MAX);
                    write_limit(pert_pkg::CFG_DRAWDOWN_LIMIT, LIM47_MAX);
                end
                1: begin
                    write_limit(pert_pkg::CFG_POSITION_LIMIT, '0);
                    write_limit(pert_pkg::CFG_STOP_LOSS_LIMIT, '0);
                    write_limit(pert_pkg::CFG_DRAWDOWN_LIMIT, '0);
                end
                2: begin
                    write_limit(pert_pkg::CFG_POSITION_LIMIT,
                                47'($urandom_range(1, 8388607)));
                    write_limit(pert_pkg::CFG_STOP_LOSS_LIMIT,
                                47'({$urandom(), $urandom()} & LIM47_MAX));
                    write_limit(pert_pkg::CFG_DRAWDOWN_LIMIT,
                                47'({$urandom(), $urandom()} & LIM47_MAX));
                    // unmapped index, must be ignored
                    write_limit(2'd3, '1);
                end
                default: begin
                    write_limit(pert_pkg::CFG_POSITION_LIMIT,
                                47'(pert_pkg::POSITION_LIMIT_RST));
                    write_limit(pert_pkg::CFG_STOP_LOSS_LIMIT, pert_pkg::STOP_LOSS_LIMIT_RST);
                    write_limit(pert_pkg::CFG_DRAWDOWN_LIMIT, pert_pkg::DRAWDOWN_LIMIT_RST);
                end
            endcase
            for (int i = 0; i < 250; i++) begin
                if (i % 120 == 0) pnl_trend = $urandom_range(0, 3);
                if (phase == 1 && i == 50) hold_off_req = 1;
                random_item();
            end
            drain();
        end

        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

FILE: sim.f
rtl/core/pert_pkg.sv
rtl/core/pert_ram.sv
rtl/core/pert_conc.sv
rtl/core/position_exposure_risk_tracker.sv
verif/position_exposure_risk_tracker_test.sv
